>>> design/pva_pkg.sv
`default_nettype none

package pva_pkg;

    localparam int NUM_VOICES = 8;
    localparam int VIDX_W     = $clog2(NUM_VOICES);
    localparam int OUT_IDX_W  = 3;
    localparam int NOTE_W     = 7;
    localparam int VEL_W      = 7;
    localparam int WHEEL_W    = 14;
    localparam int RANGE_W    = 5;
    localparam int BEND_W     = 19;
    localparam int REQ_W      = 2;
    localparam int S_DATA_W   = 32;
    localparam int M_DATA_W   = 40;
    localparam int M_USER_W   = 2;

    localparam logic [RANGE_W-1:0] RANGE_RESET = RANGE_W'(2);
    localparam logic [NOTE_W-1:0]  NOTE_RESET  = NOTE_W'(48);
    localparam logic [VIDX_W-1:0]  VIDX_LAST   = VIDX_W'(NUM_VOICES - 1);

    typedef enum logic [REQ_W-1:0] {
        REQ_NOTE_ON  = 2'd0,
        REQ_NOTE_OFF = 2'd1,
        REQ_WHEEL    = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN_ON,
        ST_SCAN_OFF,
        ST_DONE
    } t_state;

    // Write command into the voice table.
    typedef struct packed {
        logic              set;
        logic              clr;
        logic [VIDX_W-1:0] idx;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  vel;
    } t_store_cmd;

    typedef struct packed {
        logic [VEL_W-1:0]     vel;
        logic [NOTE_W-1:0]    note;
        logic                 gate;
        logic                 stolen;
        logic                 hit;
        logic [OUT_IDX_W-1:0] vidx;
    } t_result;

    function automatic logic [VIDX_W-1:0] f_inc(input logic [VIDX_W-1:0] idx);
        logic [VIDX_W-1:0] r;
        if (idx == VIDX_LAST) begin
            r = '0;
        end else begin
            r = idx + VIDX_W'(1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> design/pva_voice_store.sv
`default_nettype none

module pva_voice_store
    import pva_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_store_cmd        i_cmd,
    input  wire logic [VIDX_W-1:0] i_rd_idx,
    output logic                   o_gate,
    output logic [NOTE_W-1:0]      o_note,
    output logic [VEL_W-1:0]       o_vel
);

    logic              r_gate [NUM_VOICES];
    logic [NOTE_W-1:0] r_note [NUM_VOICES];
    logic [VEL_W-1:0]  r_vel  [NUM_VOICES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_VOICES; i++) begin
                r_gate[i] <= 1'b0;
                r_note[i] <= NOTE_RESET;
                r_vel[i]  <= '0;
            end
        end else if (i_cmd.set) begin
            r_gate[i_cmd.idx] <= 1'b1;
            r_note[i_cmd.idx] <= i_cmd.note;
            r_vel[i_cmd.idx]  <= i_cmd.vel;
        end else if (i_cmd.clr) begin
            r_gate[i_cmd.idx] <= 1'b0;
        end
    end

    assign o_gate = r_gate[i_rd_idx];
    assign o_note = r_note[i_rd_idx];
    assign o_vel  = r_vel[i_rd_idx];

endmodule

`default_nettype wire

>>> design/pva_bend.sv
`default_nettype none

module pva_bend
    import pva_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [RANGE_W-1:0] i_cfg_wdata,
    input  wire logic               i_load,
    input  wire logic [WHEEL_W-1:0] i_wheel,
    output logic [BEND_W-1:0]       o_bend
);

    logic [RANGE_W-1:0]        r_range;
    logic [BEND_W-1:0]         r_bend;
    logic signed [WHEEL_W-1:0] w_diff;
    logic signed [BEND_W:0]    w_prod;

    // Flipping the top bit is the wheel value minus center, as two's complement.
    assign w_diff = {~i_wheel[WHEEL_W-1], i_wheel[WHEEL_W-2:0]};
    assign w_prod = w_diff * $signed({1'b0, r_range});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range <= RANGE_RESET;
            r_bend  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_range <= i_cfg_wdata;
            end
            if (i_load) begin
                r_bend <= w_prod[BEND_W-1:0];
            end
        end
    end

    assign o_bend = r_bend;

endmodule

`default_nettype wire

>>> design/pva_seq.sv
`default_nettype none

module pva_seq
    import pva_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire t_req              i_req,
    input  wire logic [NOTE_W-1:0] i_req_note,
    input  wire logic [VEL_W-1:0]  i_req_vel,
    output logic                   o_in_ready,
    input  wire logic              i_gate,
    input  wire logic [NOTE_W-1:0] i_note,
    input  wire logic [VEL_W-1:0]  i_vel,
    output logic [VIDX_W-1:0]      o_rd_idx,
    output t_store_cmd             o_cmd,
    input  wire logic [BEND_W-1:0] i_bend,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output t_result                o_out,
    output logic [BEND_W-1:0]      o_out_bend
);

    t_state            r_state, n_state;
    logic [VIDX_W-1:0] r_ptr, n_ptr;
    logic [VIDX_W-1:0] r_cand, n_cand;
    logic [VIDX_W-1:0] r_cnt, n_cnt;
    logic [NOTE_W-1:0] r_note, n_note;
    logic [VEL_W-1:0]  r_vel, n_vel;
    t_result           r_res, n_res;
    t_result           r_out, n_out;
    logic [BEND_W-1:0] r_out_bend, n_out_bend;
    logic              r_out_valid, n_out_valid;

    logic w_accept, w_free, w_match, w_last, w_load;

    assign w_accept = i_in_valid && (r_state == ST_IDLE);
    assign w_free   = !i_gate;
    assign w_match  = i_gate && (i_note == r_note);
    assign w_last   = (r_cnt == VIDX_LAST);
    // The finished result moves to the output stage once that stage is free.
    assign w_load   = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (i_req)
                        REQ_NOTE_ON:  n_state = ST_SCAN_ON;
                        REQ_NOTE_OFF: n_state = ST_SCAN_OFF;
                        default:      n_state = ST_DONE;
                    endcase
                end
            end
            ST_SCAN_ON: begin
                if (w_free || w_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_SCAN_OFF: begin
                if (w_match || w_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_ptr       = r_ptr;
        n_cand      = r_cand;
        n_cnt       = r_cnt;
        n_note      = r_note;
        n_vel       = r_vel;
        n_res       = r_res;
        n_out       = r_out;
        n_out_bend  = r_out_bend;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.note  = r_note;
        o_cmd.vel   = r_vel;
        o_cmd.idx   = r_cand;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_note = i_req_note;
                    n_vel  = i_req_vel;
                    n_cnt  = '0;
                    n_res  = '0;
                    // A note-off scan starts one past the pointer.
                    n_cand = (i_req == REQ_NOTE_OFF) ? f_inc(r_ptr) : r_ptr;
                end
            end
            ST_SCAN_ON: begin
                if (w_free) begin
                    o_cmd.set = 1'b1;
                    n_ptr     = f_inc(r_cand);
                    n_res     = '{vel: r_vel, note: r_note, gate: 1'b1, stolen: 1'b0,
                                  hit: 1'b1, vidx: OUT_IDX_W'(r_cand)};
                end else if (w_last) begin
                    // Every voice is sounding: take the one after the pointer.
                    o_cmd.set = 1'b1;
                    o_cmd.idx = f_inc(r_ptr);
                    n_ptr     = f_inc(r_ptr);
                    n_res     = '{vel: r_vel, note: r_note, gate: 1'b1, stolen: 1'b1,
                                  hit: 1'b1, vidx: OUT_IDX_W'(f_inc(r_ptr))};
                end else begin
                    n_cand = f_inc(r_cand);
                    n_cnt  = r_cnt + VIDX_W'(1);
                end
            end
            ST_SCAN_OFF: begin
                if (w_match) begin
                    o_cmd.clr = 1'b1;
                    n_res     = '{vel: i_vel, note: i_note, gate: 1'b0, stolen: 1'b0,
                                  hit: 1'b1, vidx: OUT_IDX_W'(r_cand)};
                end else if (!w_last) begin
                    n_cand = f_inc(r_cand);
                    n_cnt  = r_cnt + VIDX_W'(1);
                end
            end
            ST_DONE: begin
                if (w_load) begin
                    n_out       = r_res;
                    n_out_bend  = i_bend;
                    n_out_valid = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cand     <= n_cand;
        r_cnt      <= n_cnt;
        r_note     <= n_note;
        r_vel      <= n_vel;
        r_res      <= n_res;
        r_out      <= n_out;
        r_out_bend <= n_out_bend;
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_rd_idx    = r_cand;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_out_bend  = r_out_bend;

endmodule

`default_nettype wire

>>> design/poly_voice_allocator.sv
// Channel   Dir  Handshake                   Payload
// s_axis    in   s_axis_tvalid/tready        tdata: note, velocity, wheel; tuser: request
// m_axis    out  m_axis_tvalid/tready        tdata: voice, gate, note, velocity, bend;
//                                            tuser: hit, stolen
// cfg       in   i_cfg_we (no wait)          i_cfg_wdata: bend range
//
// A note event scans the voice table one entry a cycle through a single compare unit:
// the sequencer steps idle, scan, done; a pitch wheel or unused request skips the scan.
// The result reaches m_axis at the same edge as ready returns.
// Reset is synchronous and restores all voices, the pointer, the bend and the range.
// A stalled result sits in the output stage while the next request may be taken; its
// result waits in the sequencer until the output stage is free.
`default_nettype none

module poly_voice_allocator
    import pva_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [RANGE_W-1:0]  i_cfg_wdata,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    // [6:0] note_number, [13:7] note_velocity, [27:14] wheel_value, rest zero
    input  wire logic [S_DATA_W-1:0] s_axis_tdata,
    // [1:0] req_type
    input  wire logic [REQ_W-1:0]    s_axis_tuser,
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // [2:0] voice_index, [3] gate_out, [10:4] note_out, [17:11] velocity_out,
    // [36:18] bend_out, rest zero
    output logic [M_DATA_W-1:0]      m_axis_tdata,
    // [0] hit, [1] stolen
    output logic [M_USER_W-1:0]      m_axis_tuser
);

    t_req              w_req;
    t_store_cmd        w_cmd;
    t_result           w_out;
    logic [VIDX_W-1:0] w_rd_idx;
    logic              w_gate;
    logic [NOTE_W-1:0] w_note;
    logic [VEL_W-1:0]  w_vel;
    logic [BEND_W-1:0] w_bend;
    logic [BEND_W-1:0] w_out_bend;
    logic              w_wheel_load;

    assign w_req        = t_req'(s_axis_tuser);
    assign w_wheel_load = s_axis_tvalid && s_axis_tready && (w_req == REQ_WHEEL);

    pva_voice_store u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_rd_idx (w_rd_idx),
        .o_gate   (w_gate),
        .o_note   (w_note),
        .o_vel    (w_vel)
    );

    pva_bend u_bend (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_load      (w_wheel_load),
        .i_wheel     (s_axis_tdata[27:14]),
        .o_bend      (w_bend)
    );

    pva_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_req       (w_req),
        .i_req_note  (s_axis_tdata[6:0]),
        .i_req_vel   (s_axis_tdata[13:7]),
        .o_in_ready  (s_axis_tready),
        .i_gate      (w_gate),
        .i_note      (w_note),
        .i_vel       (w_vel),
        .o_rd_idx    (w_rd_idx),
        .o_cmd       (w_cmd),
        .i_bend      (w_bend),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out       (w_out),
        .o_out_bend  (w_out_bend)
    );

    assign m_axis_tdata = {3'b000, w_out_bend, w_out.vel, w_out.note, w_out.gate, w_out.vidx};
    assign m_axis_tuser = {w_out.stolen, w_out.hit};

endmodule

`default_nettype wire

>>> design/pva_checker.sv
`default_nettype none

module pva_checker
    import pva_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                s_axis_tvalid,
    input wire logic                s_axis_tready,
    input wire logic                m_axis_tvalid,
    input wire logic                m_axis_tready,
    input wire logic [M_DATA_W-1:0] m_axis_tdata,
    input wire logic [M_USER_W-1:0] m_axis_tuser
);

    // A stalled result must not change under the consumer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // Ready is low in the cycle after every request is taken.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("ready stayed high after a transfer");

    // Stealing or opening a gate only happens on an assigned voice.
    a_flags_need_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> !m_axis_tuser[1] && !m_axis_tdata[3]
            && (m_axis_tdata[2:0] == 3'b000))
        else $error("miss result carries voice information");

    // A stolen voice is always left gated.
    a_steal_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata[3])
        else $error("stolen voice without gate");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("result or busy state survived reset");

endmodule

bind poly_voice_allocator pva_checker u_pva_checker (.*);

`default_nettype wire
